// File: rtl/sns_pkg.sv
package sns_pkg;

  localparam int WINDOW_DEPTH        = 5;
  localparam int FILL_WIDTH          = $clog2(WINDOW_DEPTH + 1);
  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int KEPT_COUNT_WIDTH    = 16;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_SEI  = 5'h06;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'h07;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'h08;

  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0]                  out_byte;
    logic                        byte_valid;
    logic                        key_frame;
    logic [4:0]                  nal_type;
    logic [KEPT_COUNT_WIDTH-1:0] kept_count;
    logic                        packet_done;
  } out_item_t;

endpackage

// File: rtl/h264_sei_nal_stripper.sv
// H.264 Annex B SEI stripper. Packet bytes arrive one per transfer on the data
// channel (end_of_packet on the final byte); every kept byte leaves as one
// transfer on the result channel, together with the running key-frame flag,
// the most recent NAL type and the kept-byte count. SEI NAL units (type 6)
// are removed together with their 3- or 4-byte start code. Start codes are
// recognized in a five-byte look-ahead window, so a byte leaves four bytes
// after it enters. Rate: one byte per clock while the packet streams and the
// result channel does not stall. At the end of a packet the window, which holds
// at most five bytes, drains through the single judge stage one byte per clock
// unless the result channel stalls, and the block accepts the next packet only
// once the window has drained and, when the last drained byte is dropped, an
// end-only marker (byte_valid = 0, packet_done = 1) has been sent instead.
// The kept count saturates at 2^COUNT_WIDTH - 1 and kept_count shows its low
// 16 bits. All per-packet state clears after the final result of a packet.
module h264_sei_nal_stripper #(
  parameter int COUNT_WIDTH = sns_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_ready,
  input  sns_pkg::in_item_t data,
  output logic              result_valid,
  input  logic              result_ready,
  output sns_pkg::out_item_t result
);
  import sns_pkg::*;

  // Look-ahead window and per-packet state
  logic [7:0]             window [WINDOW_DEPTH];
  logic [FILL_WIDTH-1:0]  fill;
  logic                   flushing;
  logic                   dropping;
  logic                   param_set_seen;
  logic [4:0]             last_nal_type;
  logic [COUNT_WIDTH-1:0] kept_total;

  logic [7:0]             window_next [WINDOW_DEPTH];
  logic [7:0]             base [WINDOW_DEPTH];
  logic [FILL_WIDTH-1:0]  fill_next;
  logic [FILL_WIDTH-1:0]  push_pos;
  logic                   flushing_next;
  logic                   dropping_next;
  logic                   param_set_seen_next;
  logic [4:0]             last_nal_type_next;
  logic [COUNT_WIDTH-1:0] kept_total_next;

  // Judge logic for the oldest window byte
  logic                   can_emit;
  logic                   judge_en;
  logic                   mark_en;
  logic                   push;
  logic                   sc3;
  logic                   sc4;
  logic [4:0]             sc_type;
  logic                   j_dropping;
  logic                   j_pset;
  logic [4:0]             j_type;
  logic [COUNT_WIDTH-1:0] j_total;
  logic                   kept;
  logic                   last_byte;
  logic                   clear_pkt;
  logic [31:0]            j_total_ext;
  logic [31:0]            total_ext;

  out_item_t result_next;

  // The output register can take a new result when empty or being drained.
  assign can_emit = !result_valid || result_ready;

  // Judge the oldest byte once four bytes follow it, or while draining.
  assign judge_en = can_emit &&
                    ((fill == FILL_WIDTH'(WINDOW_DEPTH)) ||
                     (flushing && (fill != '0)));
  // Drained window with the last byte dropped: send the end-only marker.
  assign mark_en  = can_emit && flushing && (fill == '0);

  assign data_ready = !flushing && ((fill != FILL_WIDTH'(WINDOW_DEPTH)) || can_emit);
  assign push       = data_valid && data_ready;

  // Start code detection; positions past the fill never match.
  assign sc3 = (fill >= FILL_WIDTH'(4)) && (window[0] == SC_ZERO) &&
               (window[1] == SC_ZERO) && (window[2] == SC_ONE);
  assign sc4 = (fill >= FILL_WIDTH'(5)) && (window[0] == SC_ZERO) &&
               (window[1] == SC_ZERO) && (window[2] == SC_ZERO) &&
               (window[3] == SC_ONE);
  assign sc_type = sc4 ? (window[4][4:0] & NAL_TYPE_MASK)
                       : (window[3][4:0] & NAL_TYPE_MASK);

  always_comb begin
    j_dropping = dropping;
    j_pset     = param_set_seen;
    j_type     = last_nal_type;
    if (sc3 || sc4) begin
      j_type     = sc_type;
      j_dropping = (sc_type == NAL_TYPE_SEI);
      if ((sc_type == NAL_TYPE_SPS) || (sc_type == NAL_TYPE_PPS)) begin
        j_pset = 1'b1;
      end
    end
  end

  assign kept    = !j_dropping;
  // Saturate the kept count.
  assign j_total = (kept && (kept_total != '1)) ? kept_total + COUNT_WIDTH'(1)
                                                : kept_total;
  assign j_total_ext = 32'(j_total);
  assign total_ext   = 32'(kept_total);

  // The final byte of a drain carries packet_done when kept.
  assign last_byte = flushing && (fill == FILL_WIDTH'(1));
  assign clear_pkt = (judge_en && last_byte && kept) || mark_en;

  // Shift the window down when the oldest byte is judged.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
      base[i] = judge_en ? window[i + 1] : window[i];
    end
    base[WINDOW_DEPTH-1] = judge_en ? 8'h00 : window[WINDOW_DEPTH-1];
  end

  assign push_pos = judge_en ? fill - FILL_WIDTH'(1) : fill;

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      window_next[i] = (push && (FILL_WIDTH'(i) == push_pos)) ? data.in_byte : base[i];
    end
  end

  always_comb begin
    fill_next           = fill;
    flushing_next       = flushing;
    dropping_next       = dropping;
    param_set_seen_next = param_set_seen;
    last_nal_type_next  = last_nal_type;
    kept_total_next     = kept_total;
    if (judge_en) begin
      fill_next           = fill - FILL_WIDTH'(1);
      dropping_next       = j_dropping;
      param_set_seen_next = j_pset;
      last_nal_type_next  = j_type;
      kept_total_next     = j_total;
    end
    if (push) begin
      fill_next = push_pos + FILL_WIDTH'(1);
      if (data.end_of_packet) begin
        flushing_next = 1'b1;
      end
    end
    if (clear_pkt) begin
      fill_next           = '0;
      flushing_next       = 1'b0;
      dropping_next       = 1'b0;
      param_set_seen_next = 1'b0;
      last_nal_type_next  = '0;
      kept_total_next     = '0;
    end
  end

  // Result contents: a kept byte or the end-only marker.
  always_comb begin
    if (mark_en) begin
      result_next.out_byte    = 8'h00;
      result_next.byte_valid  = 1'b0;
      result_next.key_frame   = param_set_seen;
      result_next.nal_type    = last_nal_type;
      result_next.kept_count  = total_ext[KEPT_COUNT_WIDTH-1:0];
      result_next.packet_done = 1'b1;
    end else begin
      result_next.out_byte    = window[0];
      result_next.byte_valid  = 1'b1;
      result_next.key_frame   = j_pset;
      result_next.nal_type    = j_type;
      result_next.kept_count  = j_total_ext[KEPT_COUNT_WIDTH-1:0];
      result_next.packet_done = last_byte;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
    if ((judge_en && kept) || mark_en) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      flushing       <= 1'b0;
      dropping       <= 1'b0;
      param_set_seen <= 1'b0;
      last_nal_type  <= '0;
      kept_total     <= '0;
      result_valid   <= 1'b0;
    end else begin
      fill           <= fill_next;
      flushing       <= flushing_next;
      dropping       <= dropping_next;
      param_set_seen <= param_set_seen_next;
      last_nal_type  <= last_nal_type_next;
      kept_total     <= kept_total_next;
      // Hold a waiting result, load a new one, or drop valid once taken.
      if ((judge_en && kept) || mark_en) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // No new byte enters while the window drains.
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !data_ready)
    else $error("byte accepted during window drain");

  // The window never holds more than five bytes.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_WIDTH'(WINDOW_DEPTH))
    else $error("window fill out of range");

  // An end-only marker always closes a packet and carries no byte.
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.byte_valid) |-> (result.packet_done && (result.out_byte == 8'h00)))
    else $error("malformed end marker");

  // Closing a packet clears the per-packet state.
  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    clear_pkt |=> (!flushing && (kept_total == '0) && (last_nal_type == '0)))
    else $error("packet state not cleared");

endmodule

// File: verif/testbench.sv
module testbench;
  import sns_pkg::*;

  localparam int          IDLE_LIMIT  = 2000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int          RANDOM_GOAL = 400;
  localparam logic [31:0] KEPT_MAX    = 32'((64'd1 << COUNT_WIDTH_DEFAULT) - 64'd1);

  // One directed row: the byte to send and, where it is plain to see, the single
  // result that byte must produce.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  localparam out_item_t NO_EXP = '0;
  localparam int DIRECTED_ROWS = 26;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // single byte packet, kept and closed at once
    '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b0, 5'd0, 16'd1, 1'b1}},
    // SEI only packet: everything dropped, end-only marker follows
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b0}, 1'b0, NO_EXP},
    '{'{8'h06,   1'b1}, 1'b1, '{8'h00, 1'b0, 1'b0, NAL_TYPE_SEI, 16'd0, 1'b1}},
    // 4-byte start code whose type byte is the last byte of the packet
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b0}, 1'b0, NO_EXP},
    '{'{8'h67,   1'b1}, 1'b0, NO_EXP},
    // PPS with high type bits set, SEI in the middle, then an IDR slice
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b0}, 1'b0, NO_EXP},
    '{'{8'hE8,   1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b0}, 1'b0, NO_EXP},
    '{'{8'h06,   1'b0}, 1'b0, NO_EXP},
    '{'{8'h55,   1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b0}, 1'b0, NO_EXP},
    '{'{8'h25,   1'b1}, 1'b0, NO_EXP},
    // start code cut off by the packet end: no type byte, so no NAL start
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ZERO, 1'b0}, 1'b0, NO_EXP},
    '{'{SC_ONE,  1'b1}, 1'b0, NO_EXP}
  };

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      data_valid   = 1'b0;
  logic      data_ready;
  in_item_t  data         = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  // What the checker uses for the item on the data channel right now.
  logic      row_typed = 1'b0;
  out_item_t row_want  = '0;

  h264_sei_nal_stripper dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data         (data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stripper model: look-ahead window, drop flag and per-packet totals
  // ---------------------------------------------------------------------------
  logic [7:0]  win_bytes [WINDOW_DEPTH];
  int          win_fill       = 0;
  bit          in_sei         = 1'b0;
  bit          param_set_seen = 1'b0;
  logic [4:0]  cur_nal_type   = '0;
  logic [31:0] kept_total     = '0;

  out_item_t   step_results [$];
  out_item_t   kept_bytes_due [$];
  int          bytes_taken = 0;
  int          error_count = 0;

  function automatic void clear_packet_state();
    for (int i = 0; i < WINDOW_DEPTH; i++) win_bytes[i] = SC_ZERO;
    win_fill       = 0;
    in_sei         = 1'b0;
    param_set_seen = 1'b0;
    cur_nal_type   = '0;
    kept_total     = '0;
  endfunction

  function automatic void note_nal_type(input logic [7:0] type_byte);
    cur_nal_type = type_byte[4:0] & NAL_TYPE_MASK;
    if (cur_nal_type == NAL_TYPE_SEI) begin
      in_sei = 1'b1;
    end else begin
      in_sei = 1'b0;
      if (cur_nal_type == NAL_TYPE_SPS || cur_nal_type == NAL_TYPE_PPS) param_set_seen = 1'b1;
    end
  endfunction

  function automatic void emit_result(input logic [7:0] b, input logic valid, input logic done);
    out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = valid;
    r.key_frame   = param_set_seen;
    r.nal_type    = cur_nal_type;
    r.kept_count  = kept_total[KEPT_COUNT_WIDTH-1:0];
    r.packet_done = done;
    step_results.push_back(r);
  endfunction

  // Judge the head of the window with avail bytes present, then shift it out.
  function automatic bit judge_window_head(input int avail);
    logic [7:0] head;
    bit kept;
    head = win_bytes[0];
    kept = 1'b0;
    if (avail >= 4 && win_bytes[0] == SC_ZERO && win_bytes[1] == SC_ZERO &&
        win_bytes[2] == SC_ONE)
      note_nal_type(win_bytes[3]);
    if (avail >= 5 && win_bytes[0] == SC_ZERO && win_bytes[1] == SC_ZERO &&
        win_bytes[2] == SC_ZERO && win_bytes[3] == SC_ONE)
      note_nal_type(win_bytes[4]);
    if (!in_sei) begin
      if (kept_total < KEPT_MAX) kept_total++;
      emit_result(head, 1'b1, 1'b0);
      kept = 1'b1;
    end
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_bytes[i] = win_bytes[i+1];
    win_bytes[WINDOW_DEPTH-1] = SC_ZERO;
    if (win_fill > 0) win_fill--;
    return kept;
  endfunction

  // Take one packet byte; leave the results it causes in step_results.
  function automatic void strip_take_byte(input in_item_t it);
    bit last_kept;
    bit got;
    step_results.delete();
    if (win_fill > WINDOW_DEPTH - 1) win_fill = WINDOW_DEPTH - 1;
    win_bytes[win_fill] = it.in_byte;
    win_fill++;
    if (!it.end_of_packet) begin
      if (win_fill >= WINDOW_DEPTH) got = judge_window_head(WINDOW_DEPTH);
      return;
    end
    // flush the window at packet end
    last_kept = 1'b0;
    while (win_fill > 0) begin
      got       = judge_window_head(win_fill);
      last_kept = got;
    end
    if (last_kept) step_results[step_results.size()-1].packet_done = 1'b1;
    else emit_result(SC_ZERO, 1'b0, 1'b1);
    clear_packet_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (kept_bytes_due.size() == 0) begin
      $display("%0t: result with nothing expected, got %p", $time, got);
      error_count++;
      return;
    end
    want = kept_bytes_due.pop_front();
    compare_field("out_byte",    want.out_byte,    got.out_byte);
    compare_field("byte_valid",  want.byte_valid,  got.byte_valid);
    compare_field("key_frame",   want.key_frame,   got.key_frame);
    compare_field("nal_type",    want.nal_type,    got.nal_type);
    compare_field("kept_count",  want.kept_count,  got.kept_count);
    compare_field("packet_done", want.packet_done, got.packet_done);
  endfunction

  // Predict on each input transfer before checking the result transfer of the
  // same edge, so the order inside one time step never matters.
  always @(posedge clk) begin
    if (!rst) begin
      if (data_valid && data_ready) begin
        strip_take_byte(data);
        if (row_typed) kept_bytes_due.push_back(row_want);
        else foreach (step_results[i]) kept_bytes_due.push_back(step_results[i]);
        bytes_taken++;
      end
      if (result_valid && result_ready) check_result(result);
    end
  end

  // Watchdog: too long without any transfer ends the run.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((data_valid && data_ready) || (result_valid && result_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycle through always-ready, light, heavy and periodic stalls
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 256) % 4)
      0: begin
        result_ready <= 1'b1;
      end
      1: begin
        result_ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        result_ready <= ($urandom_range(0, 9) < 3);
      end
      default: begin
        result_ready <= (rx_cycle % 5 != 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  bit         gaps_on    = 1'b0;
  int         burst_left = 0;
  logic [7:0] pkt_bytes [$];

  // Present one byte and hold it until the transfer; returns on a falling edge.
  task automatic push_byte(input in_item_t it, input logic typed, input out_item_t want);
    int target;
    target = bytes_taken + 1;
    data       <= it;
    data_valid <= 1'b1;
    row_typed  <= typed;
    row_want   <= want;
    do @(negedge clk); while (bytes_taken < target);
  endtask

  // Insert a random gap at the end of a burst, when gaps are enabled.
  task automatic sender_pause();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic send_packet();
    in_item_t it;
    foreach (pkt_bytes[i]) begin
      it.in_byte       = pkt_bytes[i];
      it.end_of_packet = (i == pkt_bytes.size() - 1);
      push_byte(it, 1'b0, NO_EXP);
      sender_pause();
    end
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0, 1:    return SC_ZERO;
      2:       return SC_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build a packet of NAL units with random types and payloads; now and then
  // pure noise, or a well-formed packet cut short.
  function automatic void build_packet();
    logic [4:0] t;
    int         cut;
    pkt_bytes.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 20)) pkt_bytes.push_back(noise_byte());
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) < 9) begin
        if ($urandom_range(0, 1)) pkt_bytes.push_back(SC_ZERO);
        pkt_bytes.push_back(SC_ZERO);
        pkt_bytes.push_back(SC_ZERO);
        pkt_bytes.push_back(SC_ONE);
        case ($urandom_range(0, 5))
          0:       t = NAL_TYPE_SEI;
          1:       t = NAL_TYPE_SPS;
          2:       t = NAL_TYPE_PPS;
          3:       t = 5'd1;
          4:       t = 5'd5;
          default: t = 5'($urandom_range(0, 31));
        endcase
        pkt_bytes.push_back({3'($urandom_range(0, 7)), t});
      end
      repeat ($urandom_range(0, 10)) begin
        pkt_bytes.push_back(($urandom_range(0, 3) == 0) ? SC_ZERO : 8'($urandom_range(0, 255)));
      end
    end
    if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_items;
    clear_packet_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows, back to back.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      push_byte(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random packets, with gaps switched on and off per packet.
    random_items = 0;
    while (random_items < RANDOM_GOAL) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      build_packet();
      random_items += pkt_bytes.size();
      send_packet();
    end

    data_valid <= 1'b0;
    while (kept_bytes_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
